[src/scara_arm_inverse_kinematics_steps_assert.svh]
// assertion macros for the arm step planner
`ifndef SCARA_ARM_INVERSE_KINEMATICS_STEPS_ASSERT_SVH
`define SCARA_ARM_INVERSE_KINEMATICS_STEPS_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SIK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SIK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sik_pkg.sv]
`timescale 1ns / 1ps
package sik_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int ANGLE_FRAC_BITS   = 16;
  localparam int TAB_FRAC          = 24;
  localparam int TAB_LEN           = 32;
  // sign plus nine integer bits covers +-360 degrees
  localparam int ANGLE_W           = ANGLE_FRAC_BITS + 10;

  localparam int COORD_W  = 17;
  localparam int LEN_W    = 16;
  localparam int SPD_W    = 32;
  localparam int JSTEP_W  = 19;
  localparam int LSTEP_W  = 21;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_ADDR_W  = 8;
  localparam int CFG_DATA_W  = 32;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_INNER_LEN = CFG_ADDR_W'(0);
  localparam cfg_addr_t CFG_OUTER_LEN = CFG_ADDR_W'(1);
  localparam cfg_addr_t CFG_SPD_Q16   = CFG_ADDR_W'(2);
  localparam cfg_addr_t CFG_LIFT_SPM  = CFG_ADDR_W'(3);

  localparam logic [LEN_W-1:0] INNER_LEN_RST = LEN_W'(30720);
  localparam logic [LEN_W-1:0] OUTER_LEN_RST = LEN_W'(32896);
  localparam logic [SPD_W-1:0] SPD_Q16_RST   = SPD_W'(46603378);
  localparam logic [LEN_W-1:0] LIFT_SPM_RST  = LEN_W'(3200);

  // atan(2^-i) in degrees, 24 fraction bits
  localparam logic [29:0] ATAN_TAB [TAB_LEN] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
    30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
    30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
    30'd234684,    30'd117342,    30'd58671,     30'd29335,
    30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115,
    30'd57,        30'd29,        30'd14,        30'd7,
    30'd4,         30'd2,         30'd1,         30'd0
  };

endpackage

[src/scara_arm_inverse_kinematics_steps.sv]
`timescale 1ns / 1ps
// Step planner for a two-link planar arm with a lift axis. Each request on the
// slave stream is a target point (x, y, z in 1/256 mm); each gives exactly one
// result with signed step counts for the elbow, the shoulder and the lift motor,
// plus an unreachable flag (y below zero, the origin, or beyond L1 + L2), in
// which case both joint counts are zero and the held joint angles stay. The
// lift moves only for z at or below zero. Joint angles come from the law of
// cosines with acos(n/d) formed as atan2(sqrt(d^2 - n^2), n); all square roots
// and atan2 passes run through one bit-serial root unit and one CORDIC rotator,
// and every product goes through one shared multiplier. A reachable point runs
// three 32-step roots and three 24-step CORDIC passes, with normalizing shifts
// ahead of each pass; an unreachable point skips all of them, and the block
// takes one request at a time and accepts the next once its result is loaded
// into the output register. Configuration writes go to cfg_addr_i registers
// 0 to 3 and are taken only while the sequencer is idle, ahead of a request
// offered in the same cycle; other indexes are ignored.
module scara_arm_inverse_kinematics_steps (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  sik_pkg::cfg_addr_t                cfg_addr_i,
  input  logic [sik_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // target in: target_x [16:0], target_y [33:17], target_z [50:34]
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [sik_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // steps out: outer_joint_steps [18:0], inner_joint_steps [37:19],
  // lift_steps [58:38]
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [sik_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // unreachable [0]
  output logic                              m_axis_tuser_o
);
  import sik_pkg::*;

  localparam int CW     = 36;  // cordic x, y, angle accumulator
  localparam int NW     = 37;  // signed acos numerator
  localparam int DW     = 36;  // acos denominator
  localparam int MA_W   = 36;
  localparam int MB_W   = 32;
  localparam int P_W    = MA_W + MB_W;
  localparam int ASHIFT = TAB_FRAC - ANGLE_FRAC_BITS;

  localparam logic signed [CW:0]   RND_C    = ((CW+1)'(1) << ASHIFT) >> 1;
  localparam logic signed [CW-1:0] C90      = CW'(64'd90 << TAB_FRAC);
  localparam logic signed [CW-1:0] C180     = CW'(64'd180 << TAB_FRAC);
  localparam logic signed [CW-1:0] NORM_LIM = CW'(64'd1 << 29);
  localparam logic [DW-1:0]        DEN_LIM  = DW'(64'd1 << 30);
  localparam logic [63:0]          SQ_TOP   = 64'd1 << 62;
  localparam logic [ANGLE_W-1:0]   INNER_RST_ANG = ANGLE_W'(64'd90 << ANGLE_FRAC_BITS);
  localparam logic [P_W-1:0] JPOS_MAX = P_W'((64'd1 << (JSTEP_W-1)) - 1);
  localparam logic [P_W-1:0] JNEG_MAX = P_W'(64'd1 << (JSTEP_W-1));
  localparam logic [P_W-1:0] LPOS_MAX = P_W'((64'd1 << (LSTEP_W-1)) - 1);
  localparam logic [P_W-1:0] LNEG_MAX = P_W'(64'd1 << (LSTEP_W-1));

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MXX   = 5'd1;
  localparam logic [4:0] S_MYY   = 5'd2;
  localparam logic [4:0] S_ML1   = 5'd3;
  localparam logic [4:0] S_ML2   = 5'd4;
  localparam logic [4:0] S_MLL   = 5'd5;
  localparam logic [4:0] S_MRCH  = 5'd6;
  localparam logic [4:0] S_CHK   = 5'd7;
  localparam logic [4:0] S_SQRT  = 5'd8;
  localparam logic [4:0] S_MLR   = 5'd9;
  localparam logic [4:0] S_ACSET = 5'd10;
  localparam logic [4:0] S_ACSH  = 5'd11;
  localparam logic [4:0] S_ACMUL = 5'd12;
  localparam logic [4:0] S_ACSQ  = 5'd13;
  localparam logic [4:0] S_CSET  = 5'd14;
  localparam logic [4:0] S_CPRE  = 5'd15;
  localparam logic [4:0] S_CNRM  = 5'd16;
  localparam logic [4:0] S_CIT   = 5'd17;
  localparam logic [4:0] S_CDONE = 5'd18;
  localparam logic [4:0] S_JSET  = 5'd19;
  localparam logic [4:0] S_JHI   = 5'd20;
  localparam logic [4:0] S_JLO   = 5'd21;
  localparam logic [4:0] S_JQ    = 5'd22;
  localparam logic [4:0] S_LIFT  = 5'd23;
  localparam logic [4:0] S_LMUL  = 5'd24;
  localparam logic [4:0] S_LQ    = 5'd25;
  localparam logic [4:0] S_FIN   = 5'd26;

  localparam logic [1:0] PH_ELBOW = 2'd0;
  localparam logic [1:0] PH_OFFS  = 2'd1;
  localparam logic [1:0] PH_ATAN  = 2'd2;

  logic [4:0] state_q, state_d;

  // config and held state
  logic [LEN_W-1:0]          l1_q, l2_q, lspm_q;
  logic [SPD_W-1:0]          spd_q;
  logic signed [ANGLE_W-1:0] held_o_q, held_i_q;
  logic signed [COORD_W-1:0] held_l_q;

  // request payload
  logic signed [COORD_W-1:0] x_q, y_q, z_q;

  // work registers
  logic [P_W-1:0]            prod_q;
  logic [34:0]               r2_q;
  logic [31:0]               l1sq_q, l2sq_q, l12_q;
  logic [33:0]               l1rr_q;
  logic [63:0]               sv_q, sr_q, sb_q;
  logic                      rr_done_q;
  logic [1:0]                ph_q;
  logic [DW-1:0]             ad_q, am_q;
  logic                      aneg_q;
  logic signed [CW-1:0]      cx_q, cy_q, cz_q, elbow_q, offs_q;
  logic [4:0]                ci_q;
  logic signed [ANGLE_W-1:0] go_q, gi_q;
  logic                      jsel_q, jneg_q;
  logic [ANGLE_W:0]          jmag_q;
  logic [P_W-1:0]            jhi_q;
  logic [JSTEP_W-1:0]        ostep_q, istep_q;
  logic                      unreach_q;
  logic                      lneg_q;
  logic [COORD_W:0]          lmag_q;
  logic [LSTEP_W-1:0]        lstep_q;

  // output register
  logic                      m_valid_q;
  logic [OUT_TDATA_W-1:0]    m_data_q;
  logic                      m_user_q;

  // combinational helpers
  logic [COORD_W-1:0]        ax, ay;
  logic [COORD_W-1:0]        reach;
  logic [MA_W-1:0]           ma;
  logic [MB_W-1:0]           mb;
  logic [P_W-1:0]            mul_p;
  logic signed [NW-1:0]      a_num;
  logic [NW-1:0]             a_mag, a_den;
  logic [63:0]               sq_t;
  logic                      sq_ge;
  logic signed [CW-1:0]      sh_x, sh_y, tab_v;
  logic                      unreach_c, z_move, c_small;
  logic signed [ANGLE_W-1:0] dsel, hsel;
  logic signed [ANGLE_W:0]   dlt;
  logic signed [COORD_W:0]   lerr;
  logic [P_W-1:0]            jq, lq;

  function automatic logic signed [ANGLE_W-1:0] to_angle(input logic signed [CW-1:0] v);
    logic signed [CW:0] s;
    s = $signed({v[CW-1], v}) + RND_C;
    return ANGLE_W'(s >>> ASHIFT);
  endfunction

  // saturate a magnitude and apply the sign
  function automatic logic [JSTEP_W-1:0] sat_j(input logic [P_W-1:0] q, input logic neg);
    logic [P_W-1:0] lim, qs;
    lim = neg ? JNEG_MAX : JPOS_MAX;
    qs  = (q > lim) ? lim : q;
    return neg ? JSTEP_W'(-qs) : JSTEP_W'(qs);
  endfunction

  function automatic logic [LSTEP_W-1:0] sat_l(input logic [P_W-1:0] q, input logic neg);
    logic [P_W-1:0] lim, qs;
    lim = neg ? LNEG_MAX : LPOS_MAX;
    qs  = (q > lim) ? lim : q;
    return neg ? LSTEP_W'(-qs) : LSTEP_W'(qs);
  endfunction

  assign ax    = x_q[COORD_W-1] ? COORD_W'(-x_q) : COORD_W'(x_q);
  assign ay    = y_q[COORD_W-1] ? COORD_W'(-y_q) : COORD_W'(y_q);
  assign reach = COORD_W'({1'b0, l1_q}) + COORD_W'({1'b0, l2_q});

  // acos operands for the current phase
  always_comb begin
    if (ph_q == PH_ELBOW) begin
      a_num = $signed({5'b0, l1sq_q}) + $signed({5'b0, l2sq_q}) - $signed({2'b0, r2_q});
      a_den = NW'({l12_q, 1'b0});
    end else begin
      a_num = $signed({5'b0, l1sq_q}) + $signed({2'b0, r2_q}) - $signed({5'b0, l2sq_q});
      a_den = NW'({l1rr_q, 1'b0});
    end
    a_mag = a_num[NW-1] ? NW'(-a_num) : NW'(a_num);
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_MXX:   begin ma = MA_W'(ax);     mb = MB_W'(ax);     end
      S_MYY:   begin ma = MA_W'(ay);     mb = MB_W'(ay);     end
      S_ML1:   begin ma = MA_W'(l1_q);   mb = MB_W'(l1_q);   end
      S_ML2:   begin ma = MA_W'(l2_q);   mb = MB_W'(l2_q);   end
      S_MLL:   begin ma = MA_W'(l1_q);   mb = MB_W'(l2_q);   end
      S_MRCH:  begin ma = MA_W'(reach);  mb = MB_W'(reach);  end
      S_MLR:   begin ma = MA_W'(l1_q);   mb = sr_q[MB_W-1:0]; end
      S_ACMUL: begin ma = MA_W'(ad_q - am_q); mb = MB_W'(ad_q + am_q); end
      S_JHI:   begin ma = MA_W'(jmag_q); mb = MB_W'(spd_q[31:16]); end
      S_JLO:   begin ma = MA_W'(jmag_q); mb = MB_W'(spd_q[15:0]);  end
      S_LMUL:  begin ma = MA_W'(lmag_q); mb = MB_W'(lspm_q); end
      default: begin ma = '0;            mb = '0;            end
    endcase
  end

  assign mul_p = ma * mb;

  // root step and cordic step
  assign sq_t    = sr_q + sb_q;
  assign sq_ge   = sv_q >= sq_t;
  assign sh_x    = cy_q >>> ci_q;
  assign sh_y    = cx_q >>> ci_q;
  assign tab_v   = CW'(ATAN_TAB[ci_q]);
  assign c_small = (cx_q < NORM_LIM) && (cy_q < NORM_LIM);

  // point check uses reach^2 straight out of the multiplier register
  assign unreach_c = y_q[COORD_W-1] || (r2_q == '0) || (P_W'(r2_q) > prod_q);
  assign z_move    = z_q[COORD_W-1] || (z_q == '0);

  assign dsel = jsel_q ? gi_q : go_q;
  assign hsel = jsel_q ? held_i_q : held_o_q;
  assign dlt  = $signed({dsel[ANGLE_W-1], dsel}) - $signed({hsel[ANGLE_W-1], hsel});
  assign lerr = $signed({z_q[COORD_W-1], z_q}) - $signed({held_l_q[COORD_W-1], held_l_q});
  assign jq   = (jhi_q + (prod_q >> 16)) >> ANGLE_FRAC_BITS;
  assign lq   = prod_q >> 8;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_axis_tvalid_i && s_axis_tready_o) state_d = S_MXX;
      S_MXX:   state_d = S_MYY;
      S_MYY:   state_d = S_ML1;
      S_ML1:   state_d = S_ML2;
      S_ML2:   state_d = S_MLL;
      S_MLL:   state_d = S_MRCH;
      S_MRCH:  state_d = S_CHK;
      S_CHK:   state_d = unreach_c ? S_LIFT : S_SQRT;
      S_SQRT:  if (sb_q[0]) state_d = rr_done_q ? S_CSET : S_MLR;
      S_MLR:   state_d = S_ACSET;
      S_ACSET: state_d = S_ACSH;
      S_ACSH:  if (ad_q < DEN_LIM) state_d = S_ACMUL;
      S_ACMUL: state_d = S_ACSQ;
      S_ACSQ:  state_d = S_SQRT;
      S_CSET:  state_d = S_CPRE;
      S_CPRE:  state_d = ((cx_q == '0) && (cy_q == '0)) ? S_CDONE : S_CNRM;
      S_CNRM:  if (!c_small) state_d = S_CIT;
      S_CIT:   if (ci_q == 5'(CORDIC_ITERATIONS - 1)) state_d = S_CDONE;
      S_CDONE: begin
        unique case (ph_q)
          PH_ELBOW: state_d = S_ACSET;
          PH_OFFS:  state_d = S_CSET;
          default:  state_d = S_JSET;
        endcase
      end
      S_JSET:  state_d = S_JHI;
      S_JHI:   state_d = S_JLO;
      S_JLO:   state_d = S_JQ;
      S_JQ:    state_d = jsel_q ? S_LIFT : S_JSET;
      S_LIFT:  state_d = z_move ? S_LMUL : S_FIN;
      S_LMUL:  state_d = S_LQ;
      S_LQ:    state_d = S_FIN;
      S_FIN:   if (!m_valid_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control, config and held angles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      l1_q      <= INNER_LEN_RST;
      l2_q      <= OUTER_LEN_RST;
      spd_q     <= SPD_Q16_RST;
      lspm_q    <= LIFT_SPM_RST;
      held_o_q  <= '0;
      held_i_q  <= INNER_RST_ANG;
      held_l_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_addr_i)
          CFG_INNER_LEN: l1_q   <= cfg_data_i[LEN_W-1:0];
          CFG_OUTER_LEN: l2_q   <= cfg_data_i[LEN_W-1:0];
          CFG_SPD_Q16:   spd_q  <= cfg_data_i[SPD_W-1:0];
          CFG_LIFT_SPM:  lspm_q <= cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (state_q == S_JQ && jsel_q) begin
        held_o_q <= go_q;
        held_i_q <= gi_q;
      end
      if (state_q == S_LQ) held_l_q <= z_q;
      if (state_q == S_FIN && !m_valid_q) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    unique case (state_q)
      S_IDLE: begin
        x_q <= s_axis_tdata_i[16:0];
        y_q <= s_axis_tdata_i[33:17];
        z_q <= s_axis_tdata_i[50:34];
      end
      S_MYY:  r2_q   <= prod_q[34:0];
      S_ML1:  r2_q   <= r2_q + prod_q[34:0];
      S_ML2:  l1sq_q <= prod_q[31:0];
      S_MLL:  l2sq_q <= prod_q[31:0];
      S_MRCH: l12_q  <= prod_q[31:0];
      S_CHK: begin
        unreach_q <= unreach_c;
        ostep_q   <= '0;
        istep_q   <= '0;
        sv_q      <= 64'(r2_q);
        sr_q      <= '0;
        sb_q      <= SQ_TOP;
        rr_done_q <= 1'b0;
      end
      S_SQRT: begin
        if (sq_ge) begin
          sv_q <= sv_q - sq_t;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      S_MLR: begin
        rr_done_q <= 1'b1;
        ph_q      <= PH_ELBOW;
      end
      S_ACSET: begin
        if (ph_q == PH_ELBOW) l1rr_q <= prod_q[33:0];
        aneg_q <= a_num[NW-1];
        ad_q   <= DW'(a_den);
        am_q   <= (a_mag > a_den) ? DW'(a_den) : DW'(a_mag);
      end
      S_ACSH: begin
        if (ad_q >= DEN_LIM) begin
          ad_q <= ad_q >> 1;
          am_q <= am_q >> 1;
        end
      end
      S_ACSQ: begin
        sv_q <= prod_q[63:0];
        sr_q <= '0;
        sb_q <= SQ_TOP;
      end
      S_CSET: begin
        if (ph_q == PH_ATAN) begin
          cx_q <= CW'(x_q);
          cy_q <= CW'(y_q);
        end else begin
          cx_q <= aneg_q ? -$signed(CW'(am_q)) : $signed(CW'(am_q));
          cy_q <= $signed(CW'(sr_q[31:0]));
        end
      end
      S_CPRE: begin
        if (cx_q[CW-1]) begin
          // quarter turn to put the vector in the right half plane
          cx_q <= cy_q;
          cy_q <= -cx_q;
          cz_q <= C90;
        end else begin
          cz_q <= '0;
        end
        ci_q <= '0;
      end
      S_CNRM: begin
        if (c_small) begin
          cx_q <= cx_q <<< 1;
          cy_q <= cy_q <<< 1;
        end
      end
      S_CIT: begin
        if (!cy_q[CW-1]) begin
          cx_q <= cx_q + sh_x;
          cy_q <= cy_q - sh_y;
          cz_q <= cz_q + tab_v;
        end else begin
          cx_q <= cx_q - sh_x;
          cy_q <= cy_q + sh_y;
          cz_q <= cz_q - tab_v;
        end
        ci_q <= ci_q + 5'd1;
      end
      S_CDONE: begin
        unique case (ph_q)
          PH_ELBOW: begin
            elbow_q <= cz_q;
            ph_q    <= PH_OFFS;
          end
          PH_OFFS: begin
            offs_q <= cz_q;
            ph_q   <= PH_ATAN;
          end
          default: begin
            go_q   <= to_angle(C180 - elbow_q);
            gi_q   <= to_angle(cz_q + offs_q);
            jsel_q <= 1'b0;
          end
        endcase
      end
      S_JSET: begin
        jneg_q <= dlt[ANGLE_W];
        jmag_q <= dlt[ANGLE_W] ? (ANGLE_W+1)'(-dlt) : (ANGLE_W+1)'(dlt);
      end
      S_JLO: jhi_q <= prod_q;
      S_JQ: begin
        if (jsel_q) istep_q <= sat_j(jq, jneg_q);
        else        ostep_q <= sat_j(jq, jneg_q);
        jsel_q <= 1'b1;
      end
      S_LIFT: begin
        lneg_q  <= lerr[COORD_W];
        lmag_q  <= lerr[COORD_W] ? (COORD_W+1)'(-lerr) : (COORD_W+1)'(lerr);
        lstep_q <= '0;
      end
      S_LQ: lstep_q <= sat_l(lq, lneg_q);
      S_FIN: begin
        if (!m_valid_q) begin
          m_data_q <= {5'b0, lstep_q, istep_q, ostep_q};
          m_user_q <= unreach_q;
        end
      end
      default: ;
    endcase
  end

  // config only while idle; a config write wins over a request in the same cycle
  assign cfg_ready_o     = (state_q == S_IDLE);
  assign s_axis_tready_o = (state_q == S_IDLE) && !cfg_valid_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

`include "scara_arm_inverse_kinematics_steps_assert.svh"

  `SIK_ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid_i && s_axis_tready_o, state_q == S_MXX, "request accepted but sequencer did not start")
  `SIK_ASSERT_NEXT(a_fin_loads_output, (state_q == S_FIN) && !m_valid_q, m_valid_q && (state_q == S_IDLE), "finished result not loaded")
  `SIK_ASSERT_NOW(a_unreach_no_joint, m_valid_q && m_user_q, m_data_q[37:0] == '0, "unreachable result carries joint steps")
  `SIK_ASSERT_NOW(a_root_bit_onehot, state_q == S_SQRT, $onehot(sb_q), "root trial bit lost")

endmodule
